// File: design/rans_interleaved_decoder_macros.svh
// Assertion macros used by the checker of the rANS decoder.
`ifndef RANS_INTERLEAVED_DECODER_MACROS_SVH
`define RANS_INTERLEAVED_DECODER_MACROS_SVH

// Check prop at every rising clock edge outside reset.
`define RID_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that post holds in the cycle after pre.
`define RID_ASSERT_NEXT(label, pre, post, msg) \
    `RID_ASSERT(label, pre |=> post, msg)

`endif

// File: design/rid_pkg.sv
package rid_pkg;

    localparam logic [2:0] CMD_BEGIN  = 3'd0;
    localparam logic [2:0] CMD_ENTRY  = 3'd1;
    localparam logic [2:0] CMD_LOAD   = 3'd2;
    localparam logic [2:0] CMD_DECODE = 3'd3;
    localparam logic [2:0] CMD_FINISH = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_ENTRY  = 3'd1;
    localparam logic [2:0] ST_INCOMPLETE = 3'd2;
    localparam logic [2:0] ST_BAD_STATE  = 3'd3;
    localparam logic [2:0] ST_UNDERRUN   = 3'd4;
    localparam logic [2:0] ST_RENORM     = 3'd5;
    localparam logic [2:0] ST_END        = 3'd6;

    localparam logic [31:0] LOWER_BOUND = 32'h0080_0000;
    localparam logic [31:0] STATE_LIMIT = 32'h8000_0000;

    localparam int SYM_BITS  = 16;
    localparam int SYM_DEPTH = 65536;

    localparam logic [16:0] ALPHA_WIDE   = 17'h10000;
    localparam logic [16:0] ALPHA_NARROW = 17'h00100;
    localparam logic [16:0] TOTAL_WIDE   = 17'h10000;
    localparam logic [16:0] TOTAL_NARROW = 17'h01000;

endpackage

// File: design/rid_ram.sv
module rid_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/rans_interleaved_decoder.sv
// Begin, load, finish, unknown and bad requests go S_EXEC, S_DONE; decode goes S_EXEC
// (slot read), S_DSYM (frequency read), S_DFC (multiply), S_DMUL (renormalize), S_DONE;
// a table entry goes S_EXEC, S_FILL (one slot write per cycle), S_DONE. One request in
// flight: the next is accepted once S_DONE has moved the result to the output register.
// Reset (rst_n low, asynchronous) clears counters, lanes, error flag and config; the
// table memories are not cleared and hold garbage until a table entry writes them.
module rans_interleaved_decoder #(
    parameter int LANES      = 4,
    parameter int TABLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [15:0] symbol_delta,
    input  logic [16:0] frequency,
    input  logic [31:0] state_word,
    input  logic [7:0]  byte_first,
    input  logic [7:0]  byte_second,
    input  logic [1:0]  bytes_available,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] symbol,
    output logic [1:0]  bytes_used,
    output logic [2:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        wide_symbols
);

    localparam int LP_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int SL_W = $clog2(LANES + 1);
    localparam logic [SL_W-1:0] LANES_CNT = SL_W'(LANES);
    localparam logic [LP_W-1:0] LAST_LANE = LP_W'(LANES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FILL,
        S_DSYM,
        S_DFC,
        S_DMUL,
        S_DONE
    } state_t;

    state_t state_reg;

    // Configuration and section state
    logic              wide_reg;
    logic              failed_reg;
    logic [16:0]       base_reg;
    logic [16:0]       ftot_reg;
    logic [LP_W-1:0]   lptr_reg;
    logic [SL_W-1:0]   sloaded_reg;
    logic [31:0]       lane_reg [LANES];

    // Held request
    logic [2:0]        cmd_reg;
    logic [15:0]       delta_reg;
    logic [16:0]       freq_reg;
    logic [31:0]       word_reg;
    logic [7:0]        b1_reg;
    logic [7:0]        b2_reg;
    logic [1:0]        avail_reg;

    // Decode and fill datapath
    logic [15:0]       sym_reg;
    logic [31:0]       x_reg;
    logic [31:0]       prod_reg;
    logic [15:0]       low_reg;
    logic [15:0]       c_reg;
    logic [16:0]       fill_addr_reg;
    logic [16:0]       fill_cnt_reg;

    // Result hold and output register
    logic [15:0]       res_sym_reg;
    logic [1:0]        res_used_reg;
    logic [2:0]        res_status_reg;
    logic              out_valid_reg;
    logic [15:0]       out_sym_reg;
    logic [1:0]        out_used_reg;
    logic [2:0]        out_status_reg;

    // Memories
    logic                   slot_we;
    logic [TABLE_BITS-1:0]  slot_waddr;
    logic [TABLE_BITS-1:0]  slot_raddr;
    logic [15:0]            slot_rdata;
    logic                   fc_we;
    logic [15:0]            fc_waddr;
    logic [32:0]            fc_wdata;
    logic [15:0]            fc_raddr;
    logic [32:0]            fc_rdata;

    rid_ram #(.WIDTH(16), .DEPTH(1 << TABLE_BITS)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (sym_reg),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // Frequency in the upper bits, cumulative start in the lower 16
    rid_ram #(.WIDTH(33), .DEPTH(rid_pkg::SYM_DEPTH)) u_fc_ram (
        .clk   (clk),
        .we    (fc_we),
        .waddr (fc_waddr),
        .wdata (fc_wdata),
        .raddr (fc_raddr),
        .rdata (fc_rdata)
    );

    logic        accept;
    logic        out_free;
    logic [16:0] alphabet;
    logic [16:0] total;
    logic [17:0] sym_sum;
    logic [17:0] ftot_sum;
    logic        entry_bad;
    logic [15:0] entry_sym;
    logic        table_full;
    logic        word_bad;
    logic        all_loaded;
    logic        all_at_lb;
    logic [31:0] lane_x;
    logic [15:0] lane_low;
    logic [19:0] x_high;
    logic [16:0] fc_freq;
    logic [36:0] prod_full;
    logic [31:0] xn;
    logic [31:0] x1;
    logic [31:0] x2;
    logic [1:0]  avail_eff;
    logic [2:0]  exec_status;
    logic [2:0]  dec_status;
    logic [1:0]  dec_used;
    logic [31:0] dec_x;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign symbol     = out_sym_reg;
    assign bytes_used = out_used_reg;
    assign status     = out_status_reg;

    // Table entry checks
    assign alphabet   = wide_reg ? rid_pkg::ALPHA_WIDE : rid_pkg::ALPHA_NARROW;
    assign total      = wide_reg ? rid_pkg::TOTAL_WIDE : rid_pkg::TOTAL_NARROW;
    assign sym_sum    = {1'b0, base_reg} + {2'b00, delta_reg};
    assign ftot_sum   = {1'b0, ftot_reg} + {1'b0, freq_reg};
    assign entry_sym  = sym_sum[15:0];
    assign entry_bad  = (sloaded_reg != '0) || ({1'b0, delta_reg} >= alphabet)
                     || (sym_sum >= {1'b0, alphabet}) || (freq_reg == '0)
                     || (ftot_reg > total) || (ftot_sum > {1'b0, total});

    // Load and finish checks
    assign table_full = (ftot_reg == total);
    assign all_loaded = (sloaded_reg == LANES_CNT);
    assign word_bad   = (sloaded_reg >= LANES_CNT) || (word_reg < rid_pkg::LOWER_BOUND)
                     || (word_reg >= rid_pkg::STATE_LIMIT);

    always_comb
    begin
        all_at_lb = 1'b1;
        for (int j = 0; j < LANES; j++)
        begin
            if (lane_reg[j] != rid_pkg::LOWER_BOUND)
            begin
                all_at_lb = 1'b0;
            end
        end
    end

    // Status of the held request in its first cycle
    always_comb
    begin
        exec_status = rid_pkg::ST_OK;
        if (failed_reg)
        begin
            exec_status = rid_pkg::ST_END;
        end
        else
        begin
            case (cmd_reg)
                rid_pkg::CMD_ENTRY:
                begin
                    if (entry_bad)
                    begin
                        exec_status = rid_pkg::ST_BAD_ENTRY;
                    end
                end
                rid_pkg::CMD_LOAD:
                begin
                    if (!table_full)
                    begin
                        exec_status = rid_pkg::ST_INCOMPLETE;
                    end
                    else if (word_bad)
                    begin
                        exec_status = rid_pkg::ST_BAD_STATE;
                    end
                end
                rid_pkg::CMD_DECODE:
                begin
                    if (!all_loaded)
                    begin
                        exec_status = rid_pkg::ST_BAD_STATE;
                    end
                end
                rid_pkg::CMD_FINISH:
                begin
                    if (!all_loaded || avail_reg != 2'd0 || !all_at_lb)
                    begin
                        exec_status = rid_pkg::ST_END;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Decode datapath
    assign lane_x    = lane_reg[lptr_reg];
    assign lane_low  = wide_reg ? lane_x[15:0] : {4'b0000, lane_x[11:0]};
    assign x_high    = wide_reg ? {4'b0000, x_reg[31:16]} : x_reg[31:12];
    assign fc_freq   = fc_rdata[32:16];
    assign prod_full = fc_freq * x_high;
    assign xn        = prod_reg + {16'h0000, low_reg} - {16'h0000, c_reg};
    assign x1        = {xn[23:0], b1_reg};
    assign x2        = {x1[23:0], b2_reg};
    assign avail_eff = (avail_reg == 2'd3) ? 2'd2 : avail_reg;

    // Renormalize: pull in up to two window bytes until the state is back in range
    always_comb
    begin
        dec_status = rid_pkg::ST_OK;
        dec_used   = 2'd0;
        dec_x      = xn;
        if (xn >= rid_pkg::LOWER_BOUND)
        begin
        end
        else if (avail_eff == 2'd0)
        begin
            dec_status = rid_pkg::ST_UNDERRUN;
        end
        else if (x1 >= rid_pkg::LOWER_BOUND)
        begin
            dec_x    = x1;
            dec_used = 2'd1;
        end
        else if (avail_eff == 2'd1)
        begin
            dec_status = rid_pkg::ST_UNDERRUN;
        end
        else if (x2 >= rid_pkg::LOWER_BOUND)
        begin
            dec_x    = x2;
            dec_used = 2'd2;
        end
        else
        begin
            dec_status = rid_pkg::ST_RENORM;
        end
    end

    // Memory ports
    assign slot_raddr = TABLE_BITS'(lane_low);
    assign slot_we    = (state_reg == S_FILL);
    assign slot_waddr = fill_addr_reg[TABLE_BITS-1:0];
    assign fc_raddr   = slot_rdata;
    assign fc_we      = (state_reg == S_EXEC) && !failed_reg
                     && (cmd_reg == rid_pkg::CMD_ENTRY) && !entry_bad;
    assign fc_waddr   = entry_sym;
    assign fc_wdata   = {freq_reg, ftot_reg[15:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wide_reg       <= 1'b0;
            failed_reg     <= 1'b0;
            base_reg       <= '0;
            ftot_reg       <= '0;
            lptr_reg       <= '0;
            sloaded_reg    <= '0;
            out_valid_reg  <= 1'b0;
            for (int j = 0; j < LANES; j++)
            begin
                lane_reg[j] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                wide_reg <= wide_symbols;
            end

            // Drain the output register once taken, unless a new result replaces it
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg   <= command;
                        delta_reg <= symbol_delta;
                        freq_reg  <= frequency;
                        word_reg  <= state_word;
                        b1_reg    <= byte_first;
                        b2_reg    <= byte_second;
                        avail_reg <= bytes_available;
                        state_reg <= S_EXEC;
                    end
                end

                S_EXEC:
                begin
                    res_sym_reg    <= '0;
                    res_used_reg   <= '0;
                    res_status_reg <= exec_status;
                    if (exec_status != rid_pkg::ST_OK)
                    begin
                        failed_reg <= 1'b1;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        case (cmd_reg)
                            rid_pkg::CMD_BEGIN:
                            begin
                                base_reg    <= '0;
                                ftot_reg    <= '0;
                                lptr_reg    <= '0;
                                sloaded_reg <= '0;
                                for (int j = 0; j < LANES; j++)
                                begin
                                    lane_reg[j] <= '0;
                                end
                                state_reg   <= S_DONE;
                            end
                            rid_pkg::CMD_ENTRY:
                            begin
                                // Fill slots ftot .. ftot+freq-1, one per cycle
                                sym_reg       <= entry_sym;
                                fill_addr_reg <= ftot_reg;
                                fill_cnt_reg  <= freq_reg;
                                ftot_reg      <= ftot_sum[16:0];
                                base_reg      <= sym_sum[16:0] + 17'd1;
                                state_reg     <= S_FILL;
                            end
                            rid_pkg::CMD_LOAD:
                            begin
                                for (int j = 0; j < LANES; j++)
                                begin
                                    if (sloaded_reg == SL_W'(j))
                                    begin
                                        lane_reg[j] <= word_reg;
                                    end
                                end
                                sloaded_reg <= sloaded_reg + SL_W'(1);
                                state_reg   <= S_DONE;
                            end
                            rid_pkg::CMD_DECODE:
                            begin
                                // Slot read issued this cycle
                                x_reg     <= lane_x;
                                low_reg   <= lane_low;
                                state_reg <= S_DSYM;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end

                S_FILL:
                begin
                    fill_addr_reg <= fill_addr_reg + 17'd1;
                    fill_cnt_reg  <= fill_cnt_reg - 17'd1;
                    if (fill_cnt_reg == 17'd1)
                    begin
                        state_reg <= S_DONE;
                    end
                end

                S_DSYM:
                begin
                    // Symbol arrives; frequency/start read issued
                    sym_reg   <= slot_rdata;
                    state_reg <= S_DFC;
                end

                S_DFC:
                begin
                    prod_reg  <= prod_full[31:0];
                    c_reg     <= fc_rdata[15:0];
                    state_reg <= S_DMUL;
                end

                S_DMUL:
                begin
                    res_sym_reg    <= sym_reg;
                    res_used_reg   <= dec_used;
                    res_status_reg <= dec_status;
                    state_reg      <= S_DONE;
                    if (dec_status == rid_pkg::ST_OK)
                    begin
                        lane_reg[lptr_reg] <= dec_x;
                        lptr_reg <= (lptr_reg == LAST_LANE) ? '0 : lptr_reg + LP_W'(1);
                    end
                    else
                    begin
                        failed_reg <= 1'b1;
                    end
                end

                S_DONE:
                begin
                    // Hold the result until the output register frees up
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_sym_reg    <= res_sym_reg;
                        out_used_reg   <= res_used_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/rid_checker.sv
`include "rans_interleaved_decoder_macros.svh"

module rid_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] symbol,
    input logic [1:0]  bytes_used,
    input logic [2:0]  status
);

    logic fail_seen_reg;
    logic fail_seen_next;

    assign fail_seen_next = fail_seen_reg
                         || (out_valid && !out_stall && status != rid_pkg::ST_OK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_seen_reg <= 1'b0;
        end
        else
        begin
            fail_seen_reg <= fail_seen_next;
        end
    end

    `RID_ASSERT_NEXT(a_in_busy, in_valid && !in_stall, in_stall, "request taken while busy")
    `RID_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
    `RID_ASSERT(a_sticky, out_valid && fail_seen_reg |-> status == rid_pkg::ST_END && symbol == 16'h0000 && bytes_used == 2'd0, "error not sticky")
    `RID_ASSERT(a_err_no_bytes, out_valid && status != rid_pkg::ST_OK |-> bytes_used == 2'd0, "bytes consumed on error")
    `RID_ASSERT(a_used_range, out_valid |-> bytes_used != 2'd3 && status <= rid_pkg::ST_END, "result code out of range")

endmodule

bind rans_interleaved_decoder rid_checker u_rid_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .symbol     (symbol),
    .bytes_used (bytes_used),
    .status     (status)
);

// File: tb/tb_rans_interleaved_decoder.sv
module tb_rans_interleaved_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LANES      = 4;
    localparam int LIMIT      = 4000000;
    localparam int ITEM_GOAL  = 2000;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] symbol_delta;
        logic [16:0] frequency;
        logic [31:0] state_word;
        logic [7:0]  byte_first;
        logic [7:0]  byte_second;
        logic [1:0]  bytes_available;
    } request_t;

    typedef struct packed {
        logic [15:0] symbol;
        logic [1:0]  bytes_used;
        logic [2:0]  status;
    } decode_result_t;

    // Directed row: request plus an optional typed-in expectation.
    typedef struct packed {
        request_t       req;
        logic           typed;
        decode_result_t res;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  command;
    logic [15:0] symbol_delta;
    logic [16:0] frequency;
    logic [31:0] state_word;
    logic [7:0]  byte_first;
    logic [7:0]  byte_second;
    logic [1:0]  bytes_available;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] symbol;
    logic [1:0]  bytes_used;
    logic [2:0]  status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        wide_symbols;

    rans_interleaved_decoder #(
        .LANES      (LANES),
        .TABLE_BITS (16)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .symbol_delta    (symbol_delta),
        .frequency       (frequency),
        .state_word      (state_word),
        .byte_first      (byte_first),
        .byte_second     (byte_second),
        .bytes_available (bytes_available),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .symbol          (symbol),
        .bytes_used      (bytes_used),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .wide_symbols    (wide_symbols)
    );

    // Shadow copy of the decoder state.
    logic [15:0] shadow_slot  [rid_pkg::SYM_DEPTH];
    logic [16:0] shadow_freq  [rid_pkg::SYM_DEPTH];
    logic [15:0] shadow_start [rid_pkg::SYM_DEPTH];
    logic [31:0] shadow_lane  [LANES];
    int unsigned shadow_base;
    int unsigned shadow_total;
    int unsigned shadow_ptr;
    int unsigned shadow_loaded;
    bit          shadow_failed;
    bit          shadow_wide;

    decode_result_t pending_results[$];

    int  mismatches;
    int  cycles;
    int  items_sent;
    int  decodes_sent;
    bit  burst_mode;
    bit  stall_mode;
    bit  hold_off;

    directed_row_t directed[$];

    // Clock: 10 ns period.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // Table entry: check the entry, then fill the slot, frequency and start stores.
    function automatic logic [2:0] entry_status(input int unsigned delta, input int unsigned f);
        int unsigned alphabet;
        int unsigned total;
        int unsigned sym;
        alphabet = shadow_wide ? 65536 : 256;
        total    = shadow_wide ? 65536 : 4096;
        if (shadow_loaded != 0 || delta >= alphabet || shadow_base > alphabet - 1 - delta ||
            f == 0 || shadow_total > total || f > total - shadow_total)
            return rid_pkg::ST_BAD_ENTRY;
        sym = shadow_base + delta;
        shadow_freq[sym[15:0]]  = f[16:0];
        shadow_start[sym[15:0]] = shadow_total[15:0];
        for (int k = 0; k < f; k++)
            shadow_slot[(shadow_total + k) & 32'hFFFF] = sym[15:0];
        shadow_total += f;
        shadow_base = sym + 1;
        return rid_pkg::ST_OK;
    endfunction

    // Work out the result of one accepted request and advance the shadow state.
    task automatic predict_decode(input request_t req, output decode_result_t res);
        int unsigned bits;
        int unsigned mask;
        int unsigned avail;
        int unsigned lane;
        int unsigned x;
        int unsigned sym;
        int unsigned used;
        logic [2:0]  st;
        bits = shadow_wide ? 16 : 12;
        mask = (1 << bits) - 1;
        sym  = 0;
        used = 0;
        st   = rid_pkg::ST_OK;
        if (shadow_failed)
            st = rid_pkg::ST_END;
        else
        begin
            case (req.command)
                rid_pkg::CMD_BEGIN:
                begin
                    shadow_base   = 0;
                    shadow_total  = 0;
                    shadow_ptr    = 0;
                    shadow_loaded = 0;
                    for (int j = 0; j < LANES; j++)
                        shadow_lane[j] = '0;
                end
                rid_pkg::CMD_ENTRY:
                    st = entry_status(req.symbol_delta, req.frequency);
                rid_pkg::CMD_LOAD:
                begin
                    if (shadow_total != (1 << bits))
                        st = rid_pkg::ST_INCOMPLETE;
                    else if (shadow_loaded >= LANES || req.state_word < rid_pkg::LOWER_BOUND ||
                             req.state_word >= rid_pkg::STATE_LIMIT)
                        st = rid_pkg::ST_BAD_STATE;
                    else
                    begin
                        shadow_lane[shadow_loaded] = req.state_word;
                        shadow_loaded++;
                    end
                end
                rid_pkg::CMD_DECODE:
                begin
                    if (shadow_loaded != LANES)
                        st = rid_pkg::ST_BAD_STATE;
                    else
                    begin
                        avail = (req.bytes_available > 2) ? 2 : req.bytes_available;
                        lane  = shadow_ptr % LANES;
                        x     = shadow_lane[lane];
                        sym   = shadow_slot[x & mask];
                        x = shadow_freq[sym] * (x >> bits) + (x & mask) - shadow_start[sym];
                        if (x < rid_pkg::LOWER_BOUND)
                        begin
                            if (avail < 1)
                                st = rid_pkg::ST_UNDERRUN;
                            else
                            begin
                                x = (x << 8) | req.byte_first;
                                used = 1;
                                if (x < rid_pkg::LOWER_BOUND)
                                begin
                                    if (avail < 2)
                                        st = rid_pkg::ST_UNDERRUN;
                                    else
                                    begin
                                        x = (x << 8) | req.byte_second;
                                        used = 2;
                                    end
                                end
                                if (st == rid_pkg::ST_OK && x < rid_pkg::LOWER_BOUND)
                                    st = rid_pkg::ST_RENORM;
                            end
                        end
                        if (st == rid_pkg::ST_OK)
                        begin
                            shadow_lane[lane] = x;
                            shadow_ptr = (lane + 1) % LANES;
                        end
                        else
                            used = 0;
                    end
                end
                rid_pkg::CMD_FINISH:
                begin
                    if (shadow_loaded != LANES || req.bytes_available != 0)
                        st = rid_pkg::ST_END;
                    else
                        for (int j = 0; j < LANES; j++)
                            if (shadow_lane[j] != rid_pkg::LOWER_BOUND)
                                st = rid_pkg::ST_END;
                end
                default: ;
            endcase
            if (st != rid_pkg::ST_OK)
                shadow_failed = 1'b1;
        end
        res.symbol     = sym[15:0];
        res.bytes_used = used[1:0];
        res.status     = st;
    endtask

    // Compare every result taken by the output side with the oldest expectation.
    always @(posedge clk)
    begin
        decode_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report($sformatf("unexpected result sym=%h used=%0d st=%0d",
                                 symbol, bytes_used, status));
            else
            begin
                want = pending_results.pop_front();
                if (symbol !== want.symbol)
                    report($sformatf("symbol %h, want %h", symbol, want.symbol));
                if (bytes_used !== want.bytes_used)
                    report($sformatf("bytes_used %0d, want %0d", bytes_used, want.bytes_used));
                if (status !== want.status)
                    report($sformatf("status %0d, want %0d", status, want.status));
            end
        end
    end

    // Output stall: random back-pressure, plus the long hold-off.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off ||
                (stall_mode && ($urandom_range(0, 99) < 30 || $urandom_range(0, 199) == 0));
    end

    // Hold the output off for a long stretch once decoding is under way, so
    // the decoder fills up and stalls its input.
    initial
    begin
        hold_off = 1'b0;
        wait (decodes_sent >= 30);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        @(negedge clk);
        hold_off = 1'b0;
    end

    function automatic int gap_len();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drive one request; expect_res is used instead of the prediction when typed is set.
    task automatic send(input request_t req, input bit typed, input decode_result_t expect_res);
        decode_result_t pred;
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid        <= 1'b1;
        command         <= req.command;
        symbol_delta    <= req.symbol_delta;
        frequency       <= req.frequency;
        state_word      <= req.state_word;
        byte_first      <= req.byte_first;
        byte_second     <= req.byte_second;
        bytes_available <= req.bytes_available;
        do
            @(posedge clk);
        while (in_stall);
        predict_decode(req, pred);
        pending_results.push_back(typed ? expect_res : pred);
        items_sent++;
        if (req.command == rid_pkg::CMD_DECODE)
            decodes_sent++;
        @(negedge clk);
    endtask

    task automatic put(input request_t req);
        send(req, 1'b0, '0);
    endtask

    function automatic request_t mk(input int unsigned cmd, input int unsigned delta,
                                    input int unsigned f, input int unsigned word,
                                    input int unsigned b1, input int unsigned b2,
                                    input int unsigned avail);
        request_t r;
        r.command         = cmd[2:0];
        r.symbol_delta    = delta[15:0];
        r.frequency       = f[16:0];
        r.state_word      = word;
        r.byte_first      = b1[7:0];
        r.byte_second     = b2[7:0];
        r.bytes_available = avail[1:0];
        return r;
    endfunction

    function automatic request_t noise_item();
        return mk($urandom_range(0, 7), $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom_range(0, 3));
    endfunction

    // Wait until every expected result is in, then let the decoder settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_cfg(input bit wide);
        wait_idle();
        cfg_valid    <= 1'b1;
        wide_symbols <= wide;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_wide = wide;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Fill a complete table of n entries; force_top puts one entry on the top symbol.
    task automatic fill_table(input int n, input bit force_top);
        int unsigned total;
        int unsigned left;
        int unsigned room;
        int unsigned base;
        int unsigned f;
        int unsigned d;
        total = shadow_wide ? 65536 : 4096;
        left  = total;
        base  = 0;
        for (int i = 0; i < n; i++)
        begin
            f = (i == n - 1) ? left : $urandom_range(1, left - (n - 1 - i));
            left -= f;
            room = (shadow_wide ? 65535 : 255) - base - (n - 1 - i);
            if (force_top && i == n - 1)
                d = room;
            else if ($urandom_range(0, 9) == 0)
                d = $urandom_range(0, room);
            else
                d = $urandom_range(0, (room > 8) ? 8 : room);
            put(mk(rid_pkg::CMD_ENTRY, d, f, $urandom, $urandom, $urandom,
                   $urandom_range(0, 3)));
            base += d + 1;
        end
    endtask

    task automatic load_lanes(input bit at_bound);
        logic [31:0] w;
        for (int j = 0; j < LANES; j++)
        begin
            w = at_bound ? rid_pkg::LOWER_BOUND
                         : $urandom_range(rid_pkg::LOWER_BOUND, rid_pkg::STATE_LIMIT - 1);
            put(mk(rid_pkg::CMD_LOAD, $urandom, $urandom, w, $urandom, $urandom,
                   $urandom_range(0, 3)));
        end
    endtask

    // One section: begin, table, lanes, decodes and no-op commands, or a clean finish.
    task automatic run_section(input bit wide, input bit force_top);
        int n;
        int m;
        bit clean_end;
        write_cfg(wide);
        burst_mode = ($urandom_range(0, 3) == 0);
        stall_mode = ($urandom_range(0, 3) != 0);
        put(mk(rid_pkg::CMD_BEGIN, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom_range(0, 3)));
        n = force_top ? 1 : $urandom_range(1, wide ? 3 : 6);
        fill_table(n, force_top);
        clean_end = ($urandom_range(0, 5) == 0);
        load_lanes(clean_end);
        if (clean_end)
            put(mk(rid_pkg::CMD_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom, 0));
        else
        begin
            m = $urandom_range(10, 40);
            for (int k = 0; k < m; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                    put(mk($urandom_range(5, 7), $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom_range(0, 3)));
                else
                    put(mk(rid_pkg::CMD_DECODE, $urandom, $urandom, $urandom,
                           $urandom, $urandom, ($urandom_range(0, 3) == 0) ? 3 : 2));
            end
        end
    endtask

    // Final section: provoke one sticky error, then send noise that must be ignored.
    task automatic run_error_section();
        int kind;
        write_cfg(1'b0);
        burst_mode = 1'b0;
        stall_mode = 1'b1;
        kind = $urandom_range(0, 5);
        put(mk(rid_pkg::CMD_BEGIN, 0, 0, 0, 0, 0, 0));
        case (kind)
            0: put(mk(rid_pkg::CMD_ENTRY, 0, 0, 0, 0, 0, 0));
            1: put(mk(rid_pkg::CMD_LOAD, 0, 0, rid_pkg::LOWER_BOUND, 0, 0, 0));
            2:
            begin
                fill_table(2, 1'b0);
                put(mk(rid_pkg::CMD_LOAD, 0, 0,
                       ($urandom_range(0, 1)) ? rid_pkg::STATE_LIMIT
                                              : rid_pkg::LOWER_BOUND - 1,
                       0, 0, 0));
            end
            3: put(mk(rid_pkg::CMD_DECODE, 0, 0, 0, 8'hFF, 8'hFF, 2));
            4:
            begin
                fill_table(3, 1'b0);
                load_lanes(1'b0);
                for (int k = 0; k < 8; k++)
                    put(mk(rid_pkg::CMD_DECODE, 0, 0, 0, $urandom, $urandom,
                           $urandom_range(0, 1)));
            end
            default:
            begin
                fill_table(1, 1'b0);
                load_lanes(1'b1);
                put(mk(rid_pkg::CMD_FINISH, 0, 0, 0, 0, 0, 1));
            end
        endcase
        for (int k = 0; k < 40; k++)
            put(noise_item());
    endtask

    task automatic build_directed();
        decode_result_t ok;
        decode_result_t none;
        ok   = '{symbol: 16'd0, bytes_used: 2'd0, status: rid_pkg::ST_OK};
        none = '0;
        directed.push_back('{mk(rid_pkg::CMD_BEGIN, 0, 0, 0, 0, 0, 0), 1'b1, ok});
        directed.push_back('{mk(rid_pkg::CMD_ENTRY, 0, 4096, 0, 0, 0, 0), 1'b1, ok});
        for (int j = 0; j < LANES; j++)
            directed.push_back('{mk(rid_pkg::CMD_LOAD, 0, 0, rid_pkg::LOWER_BOUND, 0, 0, 0),
                                 1'b1, ok});
        directed.push_back('{mk(rid_pkg::CMD_FINISH, 0, 0, 0, 0, 0, 0), 1'b1, ok});
        directed.push_back('{mk(rid_pkg::CMD_DECODE, 0, 0, 0, 8'hFF, 8'h00, 2), 1'b0, none});
        directed.push_back('{mk(5, 16'hFFFF, 17'h1FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 3),
                             1'b1, none});
        directed.push_back('{mk(rid_pkg::CMD_BEGIN, 0, 0, 0, 0, 0, 0), 1'b1, ok});
        directed.push_back('{mk(rid_pkg::CMD_ENTRY, 0, 4095, 0, 0, 0, 0), 1'b1, ok});
        directed.push_back('{mk(rid_pkg::CMD_ENTRY, 254, 1, 0, 0, 0, 0), 1'b1, ok});
        directed.push_back('{mk(rid_pkg::CMD_LOAD, 0, 0, rid_pkg::STATE_LIMIT - 1, 0, 0, 0),
                             1'b1, ok});
        directed.push_back('{mk(rid_pkg::CMD_LOAD, 0, 0, rid_pkg::LOWER_BOUND, 0, 0, 0),
                             1'b1, ok});
        directed.push_back('{mk(rid_pkg::CMD_LOAD, 0, 0, 32'h1234_5678, 0, 0, 0), 1'b1, ok});
        directed.push_back('{mk(rid_pkg::CMD_LOAD, 0, 0, rid_pkg::STATE_LIMIT - 1, 0, 0, 0),
                             1'b1, ok});
        for (int j = 0; j < 6; j++)
            directed.push_back('{mk(rid_pkg::CMD_DECODE, 0, 0, 0, (j % 2) ? 8'h00 : 8'hFF,
                                    (j % 2) ? 8'hFF : 8'h00, 2), 1'b0, none});
        directed.push_back('{mk(7, 0, 0, 0, 0, 0, 0), 1'b1, none});
    endtask

    initial
    begin
        int section;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        command         = '0;
        symbol_delta    = '0;
        frequency       = '0;
        state_word      = '0;
        byte_first      = '0;
        byte_second     = '0;
        bytes_available = '0;
        cfg_valid       = 1'b0;
        wide_symbols    = 1'b0;
        mismatches      = 0;
        cycles          = 0;
        items_sent      = 0;
        decodes_sent    = 0;
        burst_mode      = 1'b0;
        stall_mode      = 1'b1;
        shadow_base     = 0;
        shadow_total    = 0;
        shadow_ptr      = 0;
        shadow_loaded   = 0;
        shadow_failed   = 1'b0;
        shadow_wide     = 1'b0;
        for (int j = 0; j < LANES; j++)
            shadow_lane[j] = '0;
        build_directed();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed pass in narrow mode.
        write_cfg(1'b0);
        foreach (directed[i])
            send(directed[i].req, directed[i].typed, directed[i].res);

        // Random sections; a handful in wide mode, the first on the top symbol
        // with the full frequency in one entry.
        section = 0;
        while (items_sent < ITEM_GOAL)
        begin
            if (section % 15 == 7)
                run_section(1'b1, section == 7);
            else
                run_section(1'b0, $urandom_range(0, 9) == 0);
            section++;
        end
        run_error_section();

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
